// File: sv/kcl_pkg.sv
package kcl_pkg;

  localparam int unsigned CodeDigits  = 4;
  localparam int unsigned EntryDigits = 2 * CodeDigits;

  localparam logic [3:0] EntryTimeoutRst = 4'd5;
  localparam logic [7:0] LockoutRst      = 8'd60;
  localparam logic [2:0] MaxAttemptsRst  = 3'd3;

  typedef enum logic [1:0] {
    CfgEntryTimeout = 2'd0,
    CfgLockout      = 2'd1,
    CfgMaxAttempts  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ActTick   = 2'd0,
    ActKey    = 2'd1,
    ActLogin  = 2'd2,
    ActChange = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StWaiting     = 3'd0,
    StGranted     = 3'd1,
    StTimedOut    = 3'd2,
    StWrongRetry  = 3'd3,
    StBlocked     = 3'd4,
    StLockoutOver = 3'd5,
    StChanged     = 3'd6,
    StMismatch    = 3'd7
  } status_e;

  typedef struct packed {
    logic [3:0] entry_timeout;
    logic [7:0] lockout;
    logic [2:0] max_attempts;
  } cfg_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] attempts_left;
    logic [3:0] digits_entered;
    logic       blocked;
  } result_t;

endpackage

// File: sv/kcl_if.sv
interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface kcl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] attempts_left;
  logic [3:0] digits_entered;
  logic       blocked;

  modport source (output valid, output status, output attempts_left,
                  output digits_entered, output blocked, input ready);
  modport sink   (input valid, input status, input attempts_left,
                  input digits_entered, input blocked, output ready);
endinterface

// File: sv/keypad_code_lock_top.sv
// Each result is registered in the output register at its input transfer, or in the skid entry if the output stalls.
// Throughput: one item per cycle while input ready is high; the lock state updates in a single pass per item.
// Output register plus skid entry absorb one stalled result; input ready drops when both hold.
// Reset (rst_ni low, async): idle, empty entry, 3 attempts, stored code all second-key
// digits, registers at timeout 5, lockout 60, max attempts 3, output empty.
module keypad_code_lock_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  kcl_in_if.sink     in_i,
  kcl_out_if.source  out_o
);
  import kcl_pkg::*;

  cfg_t    cfg_q;
  result_t res;
  result_t out_q, skid_q;
  logic    out_vq, skid_vq;
  logic    in_fire, out_fire;

  assign in_i.ready = !skid_vq;
  assign in_fire    = in_i.valid && !skid_vq;
  assign out_fire   = out_vq && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_timeout <= EntryTimeoutRst;
      cfg_q.lockout       <= LockoutRst;
      cfg_q.max_attempts  <= MaxAttemptsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEntryTimeout: cfg_q.entry_timeout <= cfg_data_i[3:0];
        CfgLockout:      cfg_q.lockout       <= cfg_data_i;
        CfgMaxAttempts:  cfg_q.max_attempts  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  kcl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (in_fire),
    .action_i (in_i.action),
    .key_i    (in_i.key),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (in_fire) begin
      if (!out_vq || out_fire) begin
        out_vq <= 1'b1;
      end else begin
        skid_vq <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_vq) begin
        skid_vq <= 1'b0;
      end else begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_vq || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_fire && skid_vq) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid          = out_vq;
  assign out_o.status         = out_q.status;
  assign out_o.attempts_left  = out_q.attempts_left;
  assign out_o.digits_entered = out_q.digits_entered;
  assign out_o.blocked        = out_q.blocked;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vq |-> out_vq)
    else $error("skid entry held without output entry");

  a_blocked_no_attempts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && out_q.blocked |-> out_q.attempts_left == 3'd0)
    else $error("blocked result with attempts left");

  a_digits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq |-> out_q.digits_entered <= 4'(EntryDigits))
    else $error("digit count past entry bound");

  a_granted_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vq && out_q.status == StGranted |->
      out_q.digits_entered == 4'd0 && !out_q.blocked)
    else $error("granted result with open entry or blocked");

endmodule

// File: sv/kcl_core.sv
module kcl_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [1:0]       action_i,
  input  logic             key_i,
  input  kcl_pkg::cfg_t    cfg_i,
  output kcl_pkg::result_t res_o
);
  import kcl_pkg::*;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModeLogin   = 2'd1,
    ModeChange  = 2'd2,
    ModeBlocked = 2'd3
  } mode_e;

  localparam logic [3:0] CodeCnt  = 4'(CodeDigits);
  localparam logic [3:0] EntryCnt = 4'(EntryDigits);

  mode_e      mode_q, mode_d;
  logic [7:0] digits_q, digits_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] attempts_q, attempts_d;
  logic [3:0] etimer_q, etimer_d;
  logic [7:0] ltimer_q, ltimer_d;
  logic [3:0] code_q, code_d;
  logic [2:0] status;
  logic [7:0] add_digits;
  logic [3:0] add_cnt;

  always_comb begin
    add_digits = digits_q;
    add_cnt    = cnt_q;
    if (cnt_q < EntryCnt) begin
      add_digits = digits_q | ({7'd0, ~key_i} << cnt_q[2:0]);
      add_cnt    = cnt_q + 4'd1;
    end
  end

  always_comb begin
    mode_d     = mode_q;
    digits_d   = digits_q;
    cnt_d      = cnt_q;
    attempts_d = attempts_q;
    etimer_d   = etimer_q;
    ltimer_d   = ltimer_q;
    code_d     = code_q;
    status     = StWaiting;
    if (mode_q == ModeBlocked) begin
      status = StBlocked;
      if (action_i == ActTick) begin
        if (ltimer_q <= 8'd1) begin
          ltimer_d   = '0;
          attempts_d = cfg_i.max_attempts;
          mode_d     = ModeLogin;
          digits_d   = '0;
          cnt_d      = '0;
          etimer_d   = cfg_i.entry_timeout;
          status     = StLockoutOver;
        end else begin
          ltimer_d = ltimer_q - 8'd1;
        end
      end
    end else begin
      case (action_i)
        ActTick: begin
          if (mode_q == ModeLogin) begin
            if (etimer_q <= 4'd1) begin
              etimer_d = '0;
              mode_d   = ModeIdle;
              digits_d = '0;
              cnt_d    = '0;
              status   = StTimedOut;
            end else begin
              etimer_d = etimer_q - 4'd1;
            end
          end
        end
        ActLogin: begin
          mode_d     = ModeLogin;
          digits_d   = '0;
          cnt_d      = '0;
          etimer_d   = cfg_i.entry_timeout;
          attempts_d = cfg_i.max_attempts;
        end
        ActChange: begin
          mode_d   = ModeChange;
          digits_d = '0;
          cnt_d    = '0;
        end
        ActKey: begin
          if (mode_q == ModeLogin) begin
            digits_d = add_digits;
            cnt_d    = add_cnt;
            etimer_d = cfg_i.entry_timeout;
            if (add_cnt >= CodeCnt) begin
              digits_d = '0;
              cnt_d    = '0;
              if (add_digits[CodeDigits-1:0] == code_q) begin
                mode_d = ModeIdle;
                status = StGranted;
              end else if (attempts_q <= 3'd1) begin
                attempts_d = '0;
                mode_d     = ModeBlocked;
                ltimer_d   = cfg_i.lockout;
                status     = StBlocked;
              end else begin
                attempts_d = attempts_q - 3'd1;
                status     = StWrongRetry;
              end
            end
          end else if (mode_q == ModeChange) begin
            digits_d = add_digits;
            cnt_d    = add_cnt;
            if (add_cnt >= EntryCnt) begin
              if (add_digits[CodeDigits-1:0] ==
                  add_digits[EntryDigits-1:CodeDigits]) begin
                code_d = add_digits[CodeDigits-1:0];
                status = StChanged;
              end else begin
                status = StMismatch;
              end
              mode_d   = ModeIdle;
              digits_d = '0;
              cnt_d    = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o.status         = status;
    res_o.attempts_left  = attempts_d;
    res_o.digits_entered = cnt_d;
    res_o.blocked        = (mode_d == ModeBlocked);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeIdle;
      digits_q   <= '0;
      cnt_q      <= '0;
      attempts_q <= MaxAttemptsRst;
      etimer_q   <= '0;
      ltimer_q   <= '0;
      code_q     <= '0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      digits_q   <= digits_d;
      cnt_q      <= cnt_d;
      attempts_q <= attempts_d;
      etimer_q   <= etimer_d;
      ltimer_q   <= ltimer_d;
      code_q     <= code_d;
    end
  end

endmodule

// File: verif/keypad_code_lock_top_test.sv
`timescale 1ns / 1ps

module keypad_code_lock_top_test;
  import kcl_pkg::*;

  typedef enum logic [1:0] {
    LockIdle   = 2'd0,
    LockLogin  = 2'd1,
    LockChange = 2'd2,
    LockOut    = 2'd3
  } lock_mode_e;

  typedef struct packed {
    lock_mode_e mode;
    logic [7:0] digits;
    logic [3:0] count;
    logic [2:0] tries;
    logic [3:0] entry_left;
    logic [7:0] lockout_left;
    logic [3:0] code;
  } lock_state_t;

  typedef struct packed {
    action_e act;
    logic    key;
  } press_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;

  kcl_in_if  in_bus();
  kcl_out_if out_bus();

  keypad_code_lock_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  cfg_t        lock_cfg;
  lock_state_t lock_state;
  lock_state_t plan_state;
  press_t      press_q[$];
  result_t     lock_results_q[$];
  int          failures = 0;
  int          session_count;

  bit     press_taken;
  bit     result_taken;
  bit     offering;
  bit     tx_calm;
  int     tx_gap;
  bit     rx_calm;
  int     rx_wait;
  int     rx_hold;
  bit     rx_hold_req;
  press_t press_now;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic result_t predict_lock(inout lock_state_t s, input cfg_t c,
                                           input action_e act, input logic key);
    result_t r;
    status_e st;
    st = StWaiting;
    if (s.mode == LockOut) begin
      if (act == ActTick) begin
        if (s.lockout_left <= 8'd1) begin
          s.lockout_left = '0;
          s.tries = c.max_attempts;
          s.mode = LockLogin;
          s.digits = '0;
          s.count = '0;
          s.entry_left = c.entry_timeout;
          st = StLockoutOver;
        end else begin
          s.lockout_left = s.lockout_left - 1'b1;
          st = StBlocked;
        end
      end else begin
        st = StBlocked;
      end
    end else begin
      case (act)
        ActTick: begin
          if (s.mode == LockLogin) begin
            if (s.entry_left <= 4'd1) begin
              s.entry_left = '0;
              s.mode = LockIdle;
              s.digits = '0;
              s.count = '0;
              st = StTimedOut;
            end else begin
              s.entry_left = s.entry_left - 1'b1;
            end
          end
        end
        ActLogin: begin
          s.mode = LockLogin;
          s.digits = '0;
          s.count = '0;
          s.entry_left = c.entry_timeout;
          s.tries = c.max_attempts;
        end
        ActChange: begin
          s.mode = LockChange;
          s.digits = '0;
          s.count = '0;
        end
        default: begin
          if (s.mode != LockIdle && s.count < EntryDigits) begin
            // first key encodes as 1
            s.digits[s.count] = ~key;
            s.count = s.count + 1'b1;
          end
          if (s.mode == LockLogin) begin
            s.entry_left = c.entry_timeout;
            if (s.count >= CodeDigits) begin
              if (s.digits[CodeDigits-1:0] == s.code) begin
                s.mode = LockIdle;
                st = StGranted;
              end else if (s.tries <= 3'd1) begin
                s.tries = '0;
                s.mode = LockOut;
                s.lockout_left = c.lockout;
                st = StBlocked;
              end else begin
                s.tries = s.tries - 1'b1;
                st = StWrongRetry;
              end
              s.digits = '0;
              s.count = '0;
            end
          end else if (s.mode == LockChange && s.count >= EntryDigits) begin
            if (s.digits[CodeDigits-1:0] == s.digits[EntryDigits-1:CodeDigits]) begin
              s.code = s.digits[CodeDigits-1:0];
              st = StChanged;
            end else begin
              st = StMismatch;
            end
            s.mode = LockIdle;
            s.digits = '0;
            s.count = '0;
          end
        end
      endcase
    end
    r.status = st;
    r.attempts_left = s.tries;
    r.digits_entered = s.count;
    r.blocked = (s.mode == LockOut);
    return r;
  endfunction

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // sampling side: results checked before the new transfer is predicted
  always @(posedge clk_i) begin
    result_t want;
    press_taken = in_bus.valid && in_bus.ready;
    result_taken = out_bus.valid && out_bus.ready;
    if (rst_ni) begin
      if (result_taken) begin
        if (lock_results_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, out_bus.status);
          failures++;
        end else begin
          want = lock_results_q.pop_front();
          check_field("status", want.status, out_bus.status);
          check_field("attempts_left", want.attempts_left, out_bus.attempts_left);
          check_field("digits_entered", want.digits_entered, out_bus.digits_entered);
          check_field("blocked", want.blocked, out_bus.blocked);
        end
      end
      if (press_taken) begin
        lock_results_q.push_back(predict_lock(lock_state, lock_cfg,
                                              action_e'(in_bus.action), in_bus.key));
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (offering && press_taken) offering = 1'b0;
      if (!offering && press_q.size() != 0) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else begin
          press_now = press_q.pop_front();
          in_bus.action <= press_now.act;
          in_bus.key <= press_now.key;
          offering = 1'b1;
          if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
          tx_gap = tx_calm ? 0 : $urandom_range(0, 5);
        end
      end
      in_bus.valid <= offering;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold = 60;
      rx_hold_req = 1'b0;
    end
    if (result_taken) begin
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 5);
    end
    if (rx_hold != 0) begin
      rx_hold--;
      out_bus.ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  task automatic queue_press(action_e act, logic key);
    void'(predict_lock(plan_state, lock_cfg, act, key));
    press_q.push_back('{act: act, key: key});
    session_count++;
  endtask

  task automatic wait_drained();
    while (press_q.size() != 0 || offering || lock_results_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_config(logic [3:0] timeout, logic [7:0] lockout, logic [2:0] attempts);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgEntryTimeout;
    cfg_data_i <= {4'd0, timeout};
    lock_cfg.entry_timeout = timeout;
    @(negedge clk_i);
    cfg_idx_i <= CfgLockout;
    cfg_data_i <= lockout;
    lock_cfg.lockout = lockout;
    @(negedge clk_i);
    cfg_idx_i <= CfgMaxAttempts;
    cfg_data_i <= {5'd0, attempts};
    lock_cfg.max_attempts = attempts;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_session(int target);
    int         pick;
    logic [3:0] code;
    logic [3:0] half;
    logic [7:0] pair;
    session_count = 0;
    while (session_count < target) begin
      pick = $urandom_range(0, 99);
      if (plan_state.mode == LockOut) begin
        if (pick < 10) queue_press(action_e'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
        else queue_press(ActTick, 1'($urandom_range(0, 1)));
      end else if (pick < 40) begin
        if (plan_state.mode != LockLogin || pick < 28) begin
          queue_press(ActLogin, 1'($urandom_range(0, 1)));
        end
        code = $urandom_range(0, 1) ? plan_state.code : 4'($urandom_range(0, 15));
        for (int i = 0; i < CodeDigits; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, int'(lock_cfg.entry_timeout) + 1)) begin
              queue_press(ActTick, 1'($urandom_range(0, 1)));
            end
          end
          queue_press(ActKey, ~code[i]);
        end
      end else if (pick < 62) begin
        queue_press(ActChange, 1'($urandom_range(0, 1)));
        half = 4'($urandom_range(0, 15));
        pair = {($urandom_range(0, 2) != 0) ? half : 4'($urandom_range(0, 15)), half};
        for (int i = 0; i < EntryDigits; i++) begin
          if ($urandom_range(0, 19) == 0) queue_press(ActTick, 1'($urandom_range(0, 1)));
          queue_press(ActKey, ~pair[i]);
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, int'(lock_cfg.entry_timeout) + 2)) begin
          queue_press(ActTick, 1'($urandom_range(0, 1)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_press(action_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgEntryTimeout;
    cfg_data_i = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ActTick;
    in_bus.key = 1'b0;
    out_bus.ready = 1'b0;
    lock_cfg = '{entry_timeout: EntryTimeoutRst, lockout: LockoutRst,
                 max_attempts: MaxAttemptsRst};
    lock_state = '{mode: LockIdle, digits: '0, count: '0, tries: MaxAttemptsRst,
                   entry_left: '0, lockout_left: '0, code: '0};
    plan_state = lock_state;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: keys while idle, then the reset code
    queue_press(ActKey, 1'b0);
    queue_press(ActTick, 1'b1);
    queue_press(ActLogin, 1'b0);
    repeat (CodeDigits) queue_press(ActKey, 1'b1);
    wait_drained();

    // one try, short lockout: lock out, ignored input, lockout over, timeout, code change
    set_config(4'd2, 8'd2, 3'd1);
    queue_press(ActLogin, 1'b1);
    repeat (CodeDigits) queue_press(ActKey, 1'b0);
    queue_press(ActKey, 1'b1);
    queue_press(ActChange, 1'b0);
    repeat (4) queue_press(ActTick, 1'b0);
    queue_press(ActChange, 1'b1);
    for (int i = 0; i < EntryDigits; i++) queue_press(ActKey, 1'(i % 2));
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_config(4'd0, 8'd0, 3'd0);
        1: set_config(4'd15, 8'd255, 3'd7);
        2: set_config(4'd1, 8'd1, 3'd1);
        3: set_config(4'd15, 8'd0, 3'd2);
        default: set_config(4'($urandom_range(0, 15)),
                            ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 12)),
                            3'($urandom_range(0, 7)));
      endcase
      if (p == 4) rx_hold_req = 1'b1;
      random_session(150);
      wait_drained();
    end

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
